[design/spfa_pkg.sv]
package spfa_pkg;

  localparam int unsigned MaxNodesDef     = 1024;
  localparam int unsigned EdgesPerNodeDef = 8;
  localparam int unsigned DequeueCapDef   = 1048575;

  localparam int unsigned CfgW  = 11;
  localparam int unsigned NodeW = 10;
  localparam int unsigned LenW  = 16;
  localparam int unsigned DistW = 32;
  localparam int unsigned StW   = 3;

  localparam logic [DistW-1:0] Unreachable = 32'd9999999;

  localparam logic [StW-1:0] StOk      = 3'd0;
  localparam logic [StW-1:0] StUnreach = 3'd1;
  localparam logic [StW-1:0] StFull    = 3'd2;
  localparam logic [StW-1:0] StCap     = 3'd3;
  localparam logic [StW-1:0] StRange   = 3'd4;

  localparam logic OpAdd   = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic [StW-1:0]   status;
  } result_t;

  function automatic logic [DistW-1:0] sat_add(logic [DistW-1:0] a, logic [LenW-1:0] b);
    logic [DistW:0] s;
    s = {a[DistW-1], a} + {{(DistW+1-LenW){b[LenW-1]}}, b};
    if (s[DistW] != s[DistW-1]) begin
      sat_add = s[DistW] ? {1'b1, {(DistW-1){1'b0}}} : {1'b0, {(DistW-1){1'b1}}};
    end else begin
      sat_add = s[DistW-1:0];
    end
  endfunction

endpackage

[design/spfa_ram.sv]
module spfa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/spfa_shortest_path.sv]
// Channel | Direction | Payload
// s_axis  | in        | tuser: opcode; tdata: source_node, dest_node, edge_length
// m_axis  | out       | tdata: distance; tuser: status
// cfg     | in        | node_count write
// An edge add reads the edge count, then checks it and writes the edge. A query
// clears min(node_count, MAX_NODES) distance/flag entries (one per cycle), seeds
// the queue and walks it: each dequeue reads the fifo, then the node's edge count
// and distance; each edge reads the edge memory, then the target's distance and
// flag, skipping the update if the target is out of range. After reset the block
// clears the MAX_NODES edge counts. A held result stalls the next item.
module spfa_shortest_path #(
  parameter int unsigned MAX_NODES      = spfa_pkg::MaxNodesDef,
  parameter int unsigned EDGES_PER_NODE = spfa_pkg::EdgesPerNodeDef,
  parameter int unsigned DEQUEUE_CAP    = spfa_pkg::DequeueCapDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] opcode
  input  logic [0:0]  s_axis_tuser_i,
  // [9:0] source_node, [19:10] dest_node, [35:20] edge_length
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [31:0] distance
  output logic [31:0] m_axis_tdata_o,
  // [2:0] status
  output logic [2:0]  m_axis_tuser_o
);

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned EW = (EDGES_PER_NODE > 1) ? $clog2(EDGES_PER_NODE) : 1;
  localparam int unsigned CW = $clog2(EDGES_PER_NODE + 1);
  localparam int unsigned SW = NW + EW;
  localparam int unsigned SD = 2 ** SW;
  localparam int unsigned QD = 2 ** NW;
  localparam int unsigned FW = NW + 1;
  localparam int unsigned QW = $clog2(DEQUEUE_CAP + 1);
  localparam int unsigned DW = spfa_pkg::DistW;
  localparam int unsigned LW = spfa_pkg::LenW;

  localparam logic [4:0] S_RST = 5'd0, S_IDLE = 5'd1, S_ADD1 = 5'd2, S_ADD2 = 5'd3,
    S_INIT = 5'd4, S_DEQ = 5'd5, S_DEQ1 = 5'd6, S_DEQ2 = 5'd7, S_E0 = 5'd8,
    S_E1 = 5'd9, S_E2 = 5'd10, S_E3 = 5'd11, S_E4 = 5'd12, S_FIN = 5'd13,
    S_FIN1 = 5'd14, S_CAP = 5'd15, S_SEED = 5'd17;

  logic [4:0] state_q, state_d;
  logic [10:0] ncount_q;
  logic [NW:0] cnt_q, cnt_d;
  logic [9:0] src_q, dst_q;
  logic [LW-1:0] len_q;
  logic [NW-1:0] head_q, head_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [QW-1:0] deq_q, deq_d;
  logic [NW-1:0] cur_q, cur_d, tgt_q, tgt_d;
  logic [CW-1:0] ecnt_q, ecnt_d, k_q, k_d;
  logic [DW-1:0] curd_q, curd_d, cand_q, cand_d;
  logic [LW-1:0] w_q, w_d;
  spfa_pkg::result_t res_q, res_d;
  logic outv_q, outv_d;

  logic [NW:0] n_eff;
  assign n_eff = (32'(ncount_q) > MAX_NODES) ? (NW+1)'(MAX_NODES) : (NW+1)'(ncount_q);

  // memories
  logic ec_we; logic [NW-1:0] ec_wa, ec_ra; logic [CW-1:0] ec_wd, ec_rd;
  logic et_we; logic [SW-1:0] et_wa, et_ra; logic [NW+LW-1:0] et_wd, et_rd;
  logic nd_we; logic [NW-1:0] nd_wa, nd_ra; logic [DW-1:0] nd_wd, nd_rd;
  logic qf_we; logic [NW-1:0] qf_wa, qf_ra; logic qf_wd, qf_rd;
  logic wf_we; logic [NW-1:0] wf_wa, wf_ra; logic [NW-1:0] wf_wd, wf_rd;

  spfa_ram #(.Width(CW), .Depth(MAX_NODES)) u_ecnt (.clk_i, .we_i(ec_we),
    .waddr_i(ec_wa), .wdata_i(ec_wd), .raddr_i(ec_ra), .rdata_o(ec_rd));
  spfa_ram #(.Width(NW+LW), .Depth(SD)) u_edge (.clk_i, .we_i(et_we),
    .waddr_i(et_wa), .wdata_i(et_wd), .raddr_i(et_ra), .rdata_o(et_rd));
  spfa_ram #(.Width(DW), .Depth(MAX_NODES)) u_dist (.clk_i, .we_i(nd_we),
    .waddr_i(nd_wa), .wdata_i(nd_wd), .raddr_i(nd_ra), .rdata_o(nd_rd));
  spfa_ram #(.Width(1), .Depth(MAX_NODES)) u_flag (.clk_i, .we_i(qf_we),
    .waddr_i(qf_wa), .wdata_i(qf_wd), .raddr_i(qf_ra), .rdata_o(qf_rd));
  spfa_ram #(.Width(NW), .Depth(QD)) u_fifo (.clk_i, .we_i(wf_we),
    .waddr_i(wf_wa), .wdata_i(wf_wd), .raddr_i(wf_ra), .rdata_o(wf_rd));

  logic in_acc;
  assign s_axis_tready_o = (state_q == S_IDLE) && !outv_q;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = outv_q;
  assign m_axis_tdata_o = res_q.distance;
  assign m_axis_tuser_o = res_q.status;

  logic big_src, big_dst;
  assign big_src = 32'(s_axis_tdata_i[9:0]) >= MAX_NODES;
  assign big_dst = 32'(s_axis_tdata_i[19:10]) >= MAX_NODES;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; head_d = head_q; fill_d = fill_q;
    deq_d = deq_q; cur_d = cur_q; tgt_d = tgt_q; ecnt_d = ecnt_q; k_d = k_q;
    curd_d = curd_q; cand_d = cand_q; w_d = w_q; res_d = res_q;
    outv_d = outv_q && !m_axis_tready_i;
    ec_we = 1'b0; ec_wa = NW'(src_q); ec_wd = '0; ec_ra = NW'(src_q);
    et_we = 1'b0; et_wa = '0; et_wd = {NW'(dst_q), len_q};
    et_ra = {cur_q, k_q[EW-1:0]};
    nd_we = 1'b0; nd_wa = '0; nd_wd = '0; nd_ra = cur_q;
    qf_we = 1'b0; qf_wa = '0; qf_wd = 1'b0; qf_ra = tgt_q;
    wf_we = 1'b0; wf_wa = '0; wf_wd = tgt_q; wf_ra = head_q;
    case (state_q)
      S_RST: begin
        ec_we = 1'b1; ec_wa = cnt_q[NW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (NW+1)'(MAX_NODES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          cnt_d = '0;
          if (s_axis_tuser_i[0] == spfa_pkg::OpAdd) begin
            if (big_src || big_dst) begin
              res_d = '{distance: '0, status: spfa_pkg::StRange}; outv_d = 1'b1;
            end else state_d = S_ADD1;
          end else begin
            if (32'(s_axis_tdata_i[9:0]) >= 32'(n_eff) ||
                32'(s_axis_tdata_i[19:10]) >= 32'(n_eff)) begin
              res_d = '{distance: '0, status: spfa_pkg::StRange}; outv_d = 1'b1;
            end else state_d = S_INIT;
          end
        end
      end
      S_ADD1: state_d = S_ADD2;
      S_ADD2: begin
        if (ec_rd >= CW'(EDGES_PER_NODE)) begin
          res_d = '{distance: '0, status: spfa_pkg::StFull};
        end else begin
          et_we = 1'b1; et_wa = {NW'(src_q), ec_rd[EW-1:0]};
          ec_we = 1'b1; ec_wd = ec_rd + 1'b1;
          res_d = '{distance: '0, status: spfa_pkg::StOk};
        end
        outv_d = 1'b1; state_d = S_IDLE;
      end
      S_INIT: begin
        nd_we = 1'b1; nd_wa = cnt_q[NW-1:0]; nd_wd = spfa_pkg::Unreachable;
        qf_we = 1'b1; qf_wa = cnt_q[NW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == n_eff) state_d = S_SEED;
      end
      S_SEED: begin
        nd_we = 1'b1; nd_wa = NW'(src_q); nd_wd = '0;
        qf_we = 1'b1; qf_wa = NW'(src_q); qf_wd = 1'b1;
        wf_we = 1'b1; wf_wa = '0; wf_wd = NW'(src_q);
        head_d = '0; fill_d = FW'(1); deq_d = '0; state_d = S_DEQ;
      end
      S_DEQ: begin
        if (fill_q == '0) state_d = S_FIN;
        else if (deq_q >= QW'(DEQUEUE_CAP)) begin cnt_d = '0; state_d = S_CAP; end
        else begin
          deq_d = deq_q + 1'b1; head_d = head_q + 1'b1; fill_d = fill_q - 1'b1;
          state_d = S_DEQ1;
        end
      end
      S_DEQ1: begin
        cur_d = wf_rd; state_d = S_DEQ2;
      end
      S_DEQ2: begin
        // all queued nodes are below n; read count and distance of cur
        qf_we = 1'b1; qf_wa = cur_q; ec_ra = cur_q; nd_ra = cur_q;
        k_d = '0; state_d = S_E0;
      end
      S_E0: begin
        ecnt_d = ec_rd; curd_d = nd_rd;
        state_d = (ec_rd == '0) ? S_DEQ : S_E1;
      end
      S_E1: state_d = S_E2;
      S_E2: begin
        tgt_d = et_rd[NW+LW-1:LW]; w_d = et_rd[LW-1:0];
        state_d = S_E3;
      end
      S_E3: begin
        nd_ra = tgt_q; qf_ra = tgt_q;
        cand_d = spfa_pkg::sat_add(curd_q, w_q);
        if ({1'b0, tgt_q} >= n_eff) begin
          k_d = k_q + 1'b1; state_d = (k_d >= ecnt_q) ? S_DEQ : S_E1;
        end else state_d = S_E4;
      end
      S_E4: begin
        k_d = k_q + 1'b1;
        if ($signed(cand_q) < $signed(nd_rd)) begin
          nd_we = 1'b1; nd_wa = tgt_q; nd_wd = cand_q;
          if (tgt_q == cur_q) curd_d = cand_q;
          if (!qf_rd && fill_q < FW'(MAX_NODES)) begin
            wf_we = 1'b1; wf_wa = head_q + fill_q[NW-1:0];
            fill_d = fill_q + 1'b1;
            qf_we = 1'b1; qf_wa = tgt_q; qf_wd = 1'b1;
          end
        end
        state_d = (k_d >= ecnt_q) ? S_DEQ : S_E1;
      end
      S_FIN: begin nd_ra = NW'(dst_q); state_d = S_FIN1; end
      S_FIN1: begin
        if (nd_rd == spfa_pkg::Unreachable)
          res_d = '{distance: spfa_pkg::Unreachable, status: spfa_pkg::StUnreach};
        else res_d = '{distance: nd_rd, status: spfa_pkg::StOk};
        outv_d = 1'b1; state_d = S_IDLE;
      end
      S_CAP: begin
        qf_we = 1'b1; qf_wa = cnt_q[NW-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_d == n_eff) begin
          res_d = '{distance: '0, status: spfa_pkg::StCap}; outv_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RST; cnt_q <= '0; outv_q <= 1'b0; ncount_q <= '0;
      head_q <= '0; fill_q <= '0; deq_q <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; outv_q <= outv_d;
      head_q <= head_d; fill_q <= fill_d; deq_q <= deq_d;
      if (cfg_we_i) ncount_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      src_q <= s_axis_tdata_i[9:0]; dst_q <= s_axis_tdata_i[19:10];
      len_q <= s_axis_tdata_i[35:20];
    end
    cur_q <= cur_d; tgt_q <= tgt_d; ecnt_q <= ecnt_d; k_q <= k_d;
    curd_q <= curd_d; cand_q <= cand_d; w_q <= w_d; res_q <= res_d;
  end

  ast_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(MAX_NODES)) else $error("fifo overfill");
  ast_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q && !m_axis_tready_i |=> outv_q && $stable(res_q)) else $error("result lost");
  ast_noaccept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q |-> !s_axis_tready_o) else $error("accept while result held");

endmodule
